FILE: src/dfr_pkg.sv
// shared types and constants of the delimited frame receiver
`default_nettype none

package dfr_pkg;

    localparam int unsigned MAX_LEN_DEFAULT = 255;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_LOWER_P = 8'h70;
    localparam logic [7:0] CHAR_LOWER_M = 8'h6d;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_BODY  = 2'd2,
        PH_END   = 2'd3
    } frame_phase_t;

    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] xor_checksum;
        logic       overflow;
    } frame_result_t;

endpackage

`default_nettype wire

FILE: src/delimited_frame_receiver_top.sv
// top level of the delimited frame receiver: input register, parser, result register
// path: the closing 'z' waits in the input register, and the parser's result for
//   it is then captured in the result register, which drives out_valid
// throughput: one byte per cycle; the input register only stalls when it holds
//   a closing byte while the result register still waits on out_ready
// reset: rst_n is asynchronous and active low; it empties both registers and
//   returns the parser to hunting for the first header byte with zero totals
`default_nettype none

module delimited_frame_receiver_top #(
    parameter int unsigned MAX_LEN = dfr_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      frame_length,
    output logic [7:0]      xor_checksum,
    output logic            overflow
);

    // input register: holds one received byte until the parser takes it
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] byte_reg;

    // result register: holds one completed frame until the consumer takes it
    logic                   out_vld_reg;
    logic                   out_vld_next;
    dfr_pkg::frame_result_t res_reg;

    logic                   advance;
    logic                   frame_done;
    dfr_pkg::frame_result_t frame_res;
    logic                   res_room;

    // the result register has room if empty or being drained this cycle
    assign res_room = !out_vld_reg || out_ready;

    // a byte that closes no frame moves on regardless of the output side
    assign advance  = in_vld_reg && (!frame_done || res_room);
    assign in_ready = !in_vld_reg || advance;

    dfr_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .done    (frame_done),
        .result  (frame_res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance && frame_done)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload, loaded on transfer only
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
        if (advance && frame_done)
        begin
            res_reg <= frame_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign frame_length = res_reg.frame_length;
    assign xor_checksum = res_reg.xor_checksum;
    assign overflow     = res_reg.overflow;

    // a completed frame always holds both header and both trailer bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_length >= 8'd4))
        else $error("completed frame shorter than its delimiters");

    // dropped bytes only happen once the length has reached its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (frame_length == 8'(MAX_LEN)))
        else $error("overflow reported below the length limit");

    // a closing byte must not be consumed while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && frame_done && out_vld_reg && !out_ready) |-> !in_ready)
        else $error("input taken while a result could not be stored");

    // a result appears only after the parser finished a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance && frame_done))
        else $error("result raised without a completed frame");

endmodule

`default_nettype wire

FILE: src/dfr_parser.sv
// frame parser state machine with byte count and xor checksum
`default_nettype none

module dfr_parser #(
    parameter int unsigned MAX_LEN = dfr_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            rx_byte,
    output logic                       done,
    output dfr_pkg::frame_result_t     result
);

    localparam logic [7:0] LenLimit = 8'(MAX_LEN);

    dfr_pkg::frame_phase_t phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic       sum_on_reg, sum_on_next;
    logic       sum_done_reg, sum_done_next;
    logic       ovf_reg, ovf_next;

    logic       clear;
    logic       store;
    logic       is_a;
    logic       is_z;
    logic       starts_sum;
    logic [7:0] base_count;
    logic [7:0] base_xor;
    logic       base_on;
    logic       base_done;
    logic       base_ovf;

    assign is_a       = (rx_byte == dfr_pkg::CHAR_LOWER_A);
    assign is_z       = (rx_byte == dfr_pkg::CHAR_LOWER_Z);
    assign starts_sum = (rx_byte == dfr_pkg::CHAR_LOWER_P)
                     || (rx_byte == dfr_pkg::CHAR_LOWER_M);

    always_comb
    begin
        phase_next = phase_reg;
        clear      = 1'b0;
        store      = 1'b0;
        done       = 1'b0;
        unique case (phase_reg)
            dfr_pkg::PH_HUNT1:
            begin
                if (is_a)
                begin
                    clear      = 1'b1;
                    store      = 1'b1;
                    phase_next = dfr_pkg::PH_HUNT2;
                end
            end
            dfr_pkg::PH_HUNT2:
            begin
                if (is_a)
                begin
                    store      = 1'b1;
                    phase_next = dfr_pkg::PH_BODY;
                end
                else
                begin
                    phase_next = dfr_pkg::PH_HUNT1;
                end
            end
            dfr_pkg::PH_BODY:
            begin
                store = 1'b1;
                if (is_a)
                begin
                    phase_next = dfr_pkg::PH_HUNT2;
                end
                else if (is_z)
                begin
                    phase_next = dfr_pkg::PH_END;
                end
            end
            dfr_pkg::PH_END:
            begin
                // second 'z' closes the frame, anything else drops it unstored
                if (is_z)
                begin
                    store = 1'b1;
                    done  = 1'b1;
                end
                phase_next = dfr_pkg::PH_HUNT1;
            end
            default:
            begin
                phase_next = dfr_pkg::PH_HUNT1;
            end
        endcase

        // frame start wipes the previous frame's totals
        base_count = clear ? 8'd0 : count_reg;
        base_xor   = clear ? 8'd0 : xor_reg;
        base_on    = clear ? 1'b0 : sum_on_reg;
        base_done  = clear ? 1'b0 : sum_done_reg;
        base_ovf   = clear ? 1'b0 : ovf_reg;

        count_next    = base_count;
        xor_next      = base_xor;
        sum_on_next   = base_on;
        sum_done_next = base_done;
        ovf_next      = base_ovf;

        if (store)
        begin
            if (base_count >= LenLimit)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = base_count + 8'd1;
                if (!base_done)
                begin
                    if (rx_byte == dfr_pkg::CHAR_UPPER_Z)
                    begin
                        sum_done_next = 1'b1;
                    end
                    else
                    begin
                        sum_on_next = base_on | starts_sum;
                        if (base_on | starts_sum)
                        begin
                            xor_next = base_xor ^ rx_byte;
                        end
                    end
                end
            end
        end

        result.frame_length = count_next;
        result.xor_checksum = xor_next;
        result.overflow     = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= dfr_pkg::PH_HUNT1;
            count_reg    <= 8'd0;
            xor_reg      <= 8'd0;
            sum_on_reg   <= 1'b0;
            sum_done_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            sum_on_reg   <= sum_on_next;
            sum_done_reg <= sum_done_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_delimited_frame_receiver_top.sv
// self-checking testbench of the delimited frame receiver top level
module tb_delimited_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    // length cap of the instance, taken from the package default
    localparam int unsigned FRAME_CAP    = dfr_pkg::MAX_LEN_DEFAULT;
    localparam int unsigned RANDOM_BYTES = 800;
    // the result register is loaded as the closing byte leaves the input register
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned SETTLE_LIMIT = 5000;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int unsigned GAP_PERCENT  = 36;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] frame_length;
    logic [7:0] xor_checksum;
    logic       overflow;

    // bytes waiting for the driver, and frames the parser model says are due
    logic [7:0]             bytes_pending[$];
    dfr_pkg::frame_result_t frames_due[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;

    // set for one stretch of the run so that both sides stream flat out
    bit no_gaps = 1'b0;

    // parser model state, at its reset values
    dfr_pkg::frame_phase_t ph          = dfr_pkg::PH_HUNT1;
    logic [7:0]            stored_len  = 8'h00;
    logic [7:0]            csum        = 8'h00;
    logic                  csum_open   = 1'b0;
    logic                  csum_closed = 1'b0;
    logic                  len_dropped = 1'b0;

    delimited_frame_receiver_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_length (frame_length),
        .xor_checksum (xor_checksum),
        .overflow     (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one line per mismatch, and every mismatch is counted
    task automatic report_mismatch(input string what);
        $display("mismatch @%0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    // one byte that belongs to the frame: counted unless the frame is full,
    // folded into the checksum between the first 'p'/'m' and the first 'Z'
    task automatic store_in_frame(input logic [7:0] b);
        if (stored_len >= FRAME_CAP)
        begin
            len_dropped = 1'b1;
            return;
        end
        stored_len = stored_len + 8'd1;
        if (csum_closed)
            return;
        if (b == dfr_pkg::CHAR_UPPER_Z)
        begin
            csum_closed = 1'b1;
            return;
        end
        if (b == dfr_pkg::CHAR_LOWER_P || b == dfr_pkg::CHAR_LOWER_M)
            csum_open = 1'b1;
        if (csum_open)
            csum = csum ^ b;
    endtask

    // advances the model by one transferred byte and queues a frame result
    // when the closing 'z' arrives
    task automatic parse_byte(input logic [7:0] b);
        dfr_pkg::frame_result_t done;
        case (ph)
            dfr_pkg::PH_HUNT1:
            begin
                // frame start wipes whatever the last frame left behind
                if (b == dfr_pkg::CHAR_LOWER_A)
                begin
                    stored_len  = 8'h00;
                    csum        = 8'h00;
                    csum_open   = 1'b0;
                    csum_closed = 1'b0;
                    len_dropped = 1'b0;
                    store_in_frame(b);
                    ph = dfr_pkg::PH_HUNT2;
                end
            end
            dfr_pkg::PH_HUNT2:
            begin
                // a broken header keeps the stored totals until the next start
                if (b == dfr_pkg::CHAR_LOWER_A)
                begin
                    store_in_frame(b);
                    ph = dfr_pkg::PH_BODY;
                end
                else
                    ph = dfr_pkg::PH_HUNT1;
            end
            dfr_pkg::PH_BODY:
            begin
                store_in_frame(b);
                if (b == dfr_pkg::CHAR_LOWER_A)
                    ph = dfr_pkg::PH_HUNT2;
                else if (b == dfr_pkg::CHAR_LOWER_Z)
                    ph = dfr_pkg::PH_END;
            end
            default:
            begin
                // anything but a second 'z' drops the frame unstored, even an 'a'
                if (b == dfr_pkg::CHAR_LOWER_Z)
                begin
                    store_in_frame(b);
                    done.frame_length = stored_len;
                    done.xor_checksum = csum;
                    done.overflow     = len_dropped;
                    frames_due.push_back(done);
                end
                ph = dfr_pkg::PH_HUNT1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] any_byte_but(input logic [7:0] c);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == c)
            b = ~c;
        return b;
    endfunction

    // body content leaning on the characters that steer the checksum;
    // 'z' never appears here so the body stays open
    function automatic logic [7:0] pick_body_byte(input bit with_restarts);
        int unsigned roll;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (with_restarts && roll < 4)
            return dfr_pkg::CHAR_LOWER_A;
        if (roll < 14)
            return dfr_pkg::CHAR_LOWER_P;
        if (roll < 22)
            return dfr_pkg::CHAR_LOWER_M;
        if (roll < 30)
            return dfr_pkg::CHAR_UPPER_Z;
        b = 8'($urandom_range(0, 255));
        if (b == dfr_pkg::CHAR_LOWER_A || b == dfr_pkg::CHAR_LOWER_Z)
            b = ~b;
        return b;
    endfunction

    // well-formed frame; an 'a' in the body is followed by a second one so
    // the header restart lands back in the body
    task automatic queue_frame(input int unsigned body_len, input bit with_restarts);
        logic [7:0] b;
        push_byte(dfr_pkg::CHAR_LOWER_A);
        push_byte(dfr_pkg::CHAR_LOWER_A);
        for (int i = 0; i < body_len; i++)
        begin
            b = pick_body_byte(with_restarts);
            push_byte(b);
            if (b == dfr_pkg::CHAR_LOWER_A)
                push_byte(dfr_pkg::CHAR_LOWER_A);
        end
        push_byte(dfr_pkg::CHAR_LOWER_Z);
        push_byte(dfr_pkg::CHAR_LOWER_Z);
    endtask

    // noise and broken sequences
    task automatic queue_breakage();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 3);
        case (kind)
            0:
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
            1:
            begin
                // header broken after its first byte
                push_byte(dfr_pkg::CHAR_LOWER_A);
                push_byte(any_byte_but(dfr_pkg::CHAR_LOWER_A));
            end
            2:
            begin
                // end marker spoilt, sometimes by an 'a'
                push_byte(dfr_pkg::CHAR_LOWER_A);
                push_byte(dfr_pkg::CHAR_LOWER_A);
                n = $urandom_range(0, 4);
                repeat (n) push_byte(pick_body_byte(1'b0));
                push_byte(dfr_pkg::CHAR_LOWER_Z);
                push_byte($urandom_range(0, 1) ? dfr_pkg::CHAR_LOWER_A
                                               : any_byte_but(dfr_pkg::CHAR_LOWER_Z));
            end
            default:
            begin
                // frame left open: the next header continues it as a restart
                push_byte(dfr_pkg::CHAR_LOWER_A);
                push_byte(dfr_pkg::CHAR_LOWER_A);
                n = $urandom_range(0, 8);
                repeat (n) push_byte(pick_body_byte(1'b0));
            end
        endcase
    endtask

    task automatic queue_random(input int unsigned upto);
        while (bytes_queued < upto)
        begin
            if ($urandom_range(0, 99) < 78)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_frame($urandom_range(0, 60), 1'b1);
                else
                    queue_frame($urandom_range(0, 12), 1'b1);
            end
            else
                queue_breakage();
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one byte per transfer, random gaps between transfers
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else if (!in_valid || in_ready)
        begin
            // the current byte (if any) transfers at this edge, so pick the next
            if (bytes_pending.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT))
            begin
                in_valid <= 1'b1;
                rx_byte  <= bytes_pending.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
    end

    // ------------------------------------------------------------------
    // monitor: the result is checked before the byte of the same edge is
    // modelled, since that byte can only affect later results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                    report_mismatch($sformatf("unexpected frame len %0d csum %02h ovf %0b",
                                              frame_length, xor_checksum, overflow));
                else
                begin
                    if (frame_length !== frames_due[0].frame_length)
                        report_mismatch($sformatf("frame_length %0d, model %0d",
                                                  frame_length, frames_due[0].frame_length));
                    if (xor_checksum !== frames_due[0].xor_checksum)
                        report_mismatch($sformatf("xor_checksum %02h, model %02h",
                                                  xor_checksum, frames_due[0].xor_checksum));
                    if (overflow !== frames_due[0].overflow)
                        report_mismatch($sformatf("overflow %0b, model %0b",
                                                  overflow, frames_due[0].overflow));
                    void'(frames_due.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                parse_byte(rx_byte);
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        // directed part: shortest frame, header broken by 8'h00, checksum window with
        // 8'hFF, body restart, and an end spoilt by an 'a'
        push_text("aazz");
        push_byte(dfr_pkg::CHAR_LOWER_A);
        push_byte(8'h00);
        push_text("aap");
        push_byte(8'hFF);
        push_text("Zqzz");
        push_text("aamaazz");
        push_text("aaza");

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // frames right at the length cap and one past it
        queue_frame(FRAME_CAP - 4, 1'b0);
        queue_frame(FRAME_CAP - 3, 1'b0);
        queue_random(bytes_queued + 100);
        while (bytes_pending.size() != 0) @(negedge clk);

        // a stretch with both sides streaming
        no_gaps = 1'b1;
        queue_random(bytes_queued + 150);
        while (bytes_pending.size() != 0) @(negedge clk);
        no_gaps = 1'b0;

        queue_random(RANDOM_BYTES);

        // every byte transferred, then let the last frames come out
        while (bytes_taken != bytes_queued) @(negedge clk);
        for (int n = 0; n < SETTLE_LIMIT && frames_due.size() != 0; n++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (frames_due.size() != 0)
            report_mismatch($sformatf("%0d frames never came out", frames_due.size()));

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #RUN_LIMIT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
